### hdl/hmbs_pkg.sv
// Shared constants, types and codes of the heightmap bilinear sampler.
`timescale 1ns / 1ps
`default_nettype none

package hmbs_pkg;

    // Map limits and fixed-point format
    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int FRACTION_BITS = 8;

    // Field widths fixed by the interface
    localparam int CMD_BITS     = 1;
    localparam int FIELD_BITS   = 8;
    localparam int SAMPLE_BITS  = 8;
    localparam int POS_BITS     = 17;
    localparam int HEIGHT_BITS  = 14;
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 1;

    // Store geometry: four banks split by row parity and column parity
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
    localparam int BANK_COL_BITS  = COL_BITS - 1;
    localparam int BANK_ROW_BITS  = ROW_BITS - 1;
    localparam int BANK_ADDR_BITS = BANK_ROW_BITS + BANK_COL_BITS;
    localparam int BANK_DEPTH     = 1 << BANK_ADDR_BITS;
    localparam int BANKS          = 4;
    localparam int BANK_SEL_BITS  = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MAP_WIDTH  = 1'b0,
        REG_MAP_HEIGHT = 1'b1
    } reg_idx_t;

    typedef logic [SAMPLE_BITS-1:0]    sample_t;
    typedef logic [BANK_ADDR_BITS-1:0] bank_addr_t;
    typedef logic [BANK_SEL_BITS-1:0]  bank_sel_t;

    typedef logic [BANKS-1:0][BANK_ADDR_BITS-1:0] bank_addrs_t;
    typedef logic [BANKS-1:0][SAMPLE_BITS-1:0]    bank_data_t;

    // One sample write into the banked store
    typedef struct packed {
        logic       en;
        bank_sel_t  bank;
        bank_addr_t addr;
        sample_t    data;
    } store_wr_t;

endpackage

`default_nettype wire

### hdl/hmbs_store.sv
// Banked heightmap store: one write and four registered reads per cycle.
`timescale 1ns / 1ps
`default_nettype none

module hmbs_store (
    input  wire                     aclk,
    input  wire hmbs_pkg::store_wr_t   wr,
    input  wire                     rd_en,
    input  wire hmbs_pkg::bank_addrs_t rd_addr,
    output wire hmbs_pkg::bank_data_t rd_data
);
    import hmbs_pkg::*;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        sample_t mem_reg [BANK_DEPTH];
        sample_t rd_q_reg;

        always_ff @(posedge aclk) begin
            if (wr.en && (wr.bank == BANK_SEL_BITS'(b))) begin
                mem_reg[wr.addr] <= wr.data;
            end
            if (rd_en) begin
                rd_q_reg <= mem_reg[rd_addr[b]];
            end
        end

        assign rd_data[b] = rd_q_reg;
    end

endmodule

`default_nettype wire

### hdl/heightmap_bilinear_sampler_top.sv
// Top level of the heightmap bilinear sampler: request pipeline and configuration.
`timescale 1ns / 1ps
`default_nettype none

// Heightmap bilinear sampler. Each request is either a sample write (command 0),
// which stores one 8-bit height at (sample_row, sample_column) and returns nothing,
// or a height query (command 1), which returns one result: the bilinear blend of
// the four samples around (pos_x, pos_z), divided by six, in Q8.8 truncated, or
// height 0 with out_of_range set when the position is negative or past the last
// column/row of the configured map (a position exactly on the last column or row
// is in range). The block takes one request per clock cycle unless the output
// holds an untaken result; a query passes the stage 0 to 3 registers and the output
// register on its way to m_valid. The rate comes from the store, split into four
// banks by row and column parity so that all four neighbors of a query are read
// in the same cycle. The store is not cleared at reset: query only positions whose
// samples have been written. Write map_width (index 0) and map_height (index 1)
// only while no request is in flight; values are clamped to 1..256.

module heightmap_bilinear_sampler_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    // configuration
    input  wire                               cfg_write,
    input  wire [hmbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire [hmbs_pkg::CFG_BITS-1:0]      cfg_data,
    // request channel
    input  wire                               s_valid,
    output logic                              s_ready,
    input  wire [hmbs_pkg::CMD_BITS-1:0]      s_command,
    input  wire [hmbs_pkg::FIELD_BITS-1:0]    s_sample_column,
    input  wire [hmbs_pkg::FIELD_BITS-1:0]    s_sample_row,
    input  wire [hmbs_pkg::SAMPLE_BITS-1:0]   s_sample_value,
    input  wire signed [hmbs_pkg::POS_BITS-1:0] s_pos_x,
    input  wire signed [hmbs_pkg::POS_BITS-1:0] s_pos_z,
    // result channel
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [hmbs_pkg::HEIGHT_BITS-1:0]  m_height,
    output logic                              m_out_of_range
);
    import hmbs_pkg::*;

    localparam int F         = FRACTION_BITS;
    localparam int LIM_X     = COL_BITS + F;
    localparam int LIM_Z     = ROW_BITS + F;
    localparam int CMP_BITS  = (POS_BITS > LIM_X) ? ((POS_BITS > LIM_Z) ? POS_BITS : LIM_Z)
                                                  : ((LIM_X > LIM_Z) ? LIM_X : LIM_Z);
    localparam int WGT_BITS  = F + 1;
    localparam int TOP_BITS  = SAMPLE_BITS + F;
    localparam int PROD1_BITS = TOP_BITS + 1;
    localparam int BLEND_BITS = SAMPLE_BITS + 2 * F;
    localparam int PROD2_BITS = BLEND_BITS + 1;
    // Result is blend * 256 / (6 * 2^2F) = (blend >> (2F - 8)) / 6
    localparam int Q_SHIFT    = 2 * F - 8;
    localparam int Q_BITS     = SAMPLE_BITS + 8;
    // floor(q / 6) == (q * 43691) >> 18, exact for q below 2^17
    localparam int DIV6_BITS  = 16;
    localparam logic [DIV6_BITS-1:0] DIV6_MUL = 16'd43691;
    localparam int DIV6_SHIFT = 18;
    localparam int DIVP_BITS  = Q_BITS + DIV6_BITS;
    localparam logic [WGT_BITS-1:0] ONE = WGT_BITS'(1) << F;

    // ------------------------------------------------------------------
    // Configuration: keep last column and last row index, clamped
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0] wm1_reg;
    logic [ROW_BITS-1:0] hm1_reg;
    logic [COL_BITS-1:0] wm1_next;
    logic [ROW_BITS-1:0] hm1_next;

    always_comb begin
        if (cfg_data == '0) begin
            wm1_next = '0;
        end else if (int'(cfg_data) > MAX_WIDTH) begin
            wm1_next = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            wm1_next = COL_BITS'(cfg_data - CFG_BITS'(1));
        end
        if (cfg_data == '0) begin
            hm1_next = '0;
        end else if (int'(cfg_data) > MAX_HEIGHT) begin
            hm1_next = ROW_BITS'(MAX_HEIGHT - 1);
        end else begin
            hm1_next = ROW_BITS'(cfg_data - CFG_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wm1_reg <= COL_BITS'(MAX_WIDTH - 1);
            hm1_reg <= ROW_BITS'(MAX_HEIGHT - 1);
        end else if (cfg_write) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MAP_WIDTH:  wm1_reg <= wm1_next;
                REG_MAP_HEIGHT: hm1_reg <= hm1_next;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the output
    // register holds an untaken result
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // Stage 0: request register
    // ------------------------------------------------------------------
    logic                       s0_valid_reg;
    logic [CMD_BITS-1:0]        s0_cmd_reg;
    logic [FIELD_BITS-1:0]      s0_col_reg;
    logic [FIELD_BITS-1:0]      s0_row_reg;
    sample_t                    s0_value_reg;
    logic [POS_BITS-1:0]        s0_pos_x_reg;
    logic [POS_BITS-1:0]        s0_pos_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_cmd_reg   <= s_command;
            s0_col_reg   <= s_sample_column;
            s0_row_reg   <= s_sample_row;
            s0_value_reg <= s_sample_value;
            s0_pos_x_reg <= s_pos_x;
            s0_pos_z_reg <= s_pos_z;
        end
    end

    // Range check, integer/fraction split and bank addressing
    logic                 s0_query;
    logic                 s0_write;
    logic                 oor_next;
    logic [COL_BITS-1:0]  x0;
    logic [ROW_BITS-1:0]  z0;
    logic [F-1:0]         fx_next;
    logic [F-1:0]         fz_next;
    logic [BANK_COL_BITS-1:0] x_even_addr;
    logic [BANK_COL_BITS-1:0] x_odd_addr;
    logic [BANK_ROW_BITS-1:0] z_even_addr;
    logic [BANK_ROW_BITS-1:0] z_odd_addr;
    bank_addrs_t          rd_addr;
    store_wr_t            wr;
    logic                 wr_in_map;

    assign s0_query = s0_valid_reg && (s0_cmd_reg == CMD_QUERY);
    assign s0_write = s0_valid_reg && (s0_cmd_reg == CMD_WRITE);

    always_comb begin
        oor_next = s0_pos_x_reg[POS_BITS-1] || s0_pos_z_reg[POS_BITS-1]
                || (CMP_BITS'(s0_pos_x_reg) > CMP_BITS'({wm1_reg, F'(0)}))
                || (CMP_BITS'(s0_pos_z_reg) > CMP_BITS'({hm1_reg, F'(0)}));
        x0      = s0_pos_x_reg[F +: COL_BITS];
        z0      = s0_pos_z_reg[F +: ROW_BITS];
        fx_next = s0_pos_x_reg[F-1:0];
        fz_next = s0_pos_z_reg[F-1:0];
        // Even bank holds x0 (x0 even) or x0 + 1 (x0 odd); odd bank the other one
        x_odd_addr  = x0[COL_BITS-1:1];
        x_even_addr = x0[COL_BITS-1:1] + BANK_COL_BITS'(x0[0]);
        z_odd_addr  = z0[ROW_BITS-1:1];
        z_even_addr = z0[ROW_BITS-1:1] + BANK_ROW_BITS'(z0[0]);
        // Bank index is {row parity, column parity}
        rd_addr[0] = {z_even_addr, x_even_addr};
        rd_addr[1] = {z_even_addr, x_odd_addr};
        rd_addr[2] = {z_odd_addr,  x_even_addr};
        rd_addr[3] = {z_odd_addr,  x_odd_addr};
    end

    always_comb begin
        wr_in_map = (int'(s0_col_reg) < MAX_WIDTH) && (int'(s0_row_reg) < MAX_HEIGHT);
        wr.en     = adv && s0_write && wr_in_map;
        wr.bank   = {s0_row_reg[0], s0_col_reg[0]};
        wr.addr   = {BANK_ROW_BITS'(ROW_BITS'(s0_row_reg) >> 1),
                     BANK_COL_BITS'(COL_BITS'(s0_col_reg) >> 1)};
        wr.data   = s0_value_reg;
    end

    bank_data_t rd_data;

    hmbs_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (adv && s0_query),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: samples out of the banks, horizontal blends
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic          s1_oor_reg;
    logic [F-1:0]  s1_fx_reg;
    logic [F-1:0]  s1_fz_reg;
    logic          s1_xsel0_reg;
    logic          s1_xsel1_reg;
    logic          s1_zsel0_reg;
    logic          s1_zsel1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s0_query;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_oor_reg   <= oor_next;
            s1_fx_reg    <= fx_next;
            s1_fz_reg    <= fz_next;
            // On a whole coordinate the far neighbor is the near one itself
            s1_xsel0_reg <= x0[0];
            s1_xsel1_reg <= x0[0] ^ (fx_next != '0);
            s1_zsel0_reg <= z0[0];
            s1_zsel1_reg <= z0[0] ^ (fz_next != '0);
        end
    end

    sample_t                s00, s01, s10, s11;
    logic [WGT_BITS-1:0]    wx0;
    logic [PROD1_BITS-1:0]  top_sum, bottom_sum;
    logic [TOP_BITS-1:0]    top_next, bottom_next;

    always_comb begin
        s00 = rd_data[{s1_zsel0_reg, s1_xsel0_reg}];
        s01 = rd_data[{s1_zsel0_reg, s1_xsel1_reg}];
        s10 = rd_data[{s1_zsel1_reg, s1_xsel0_reg}];
        s11 = rd_data[{s1_zsel1_reg, s1_xsel1_reg}];
        wx0 = ONE - WGT_BITS'(s1_fx_reg);
        top_sum    = PROD1_BITS'(s00) * PROD1_BITS'(wx0)
                   + PROD1_BITS'(s01) * PROD1_BITS'(s1_fx_reg);
        bottom_sum = PROD1_BITS'(s10) * PROD1_BITS'(wx0)
                   + PROD1_BITS'(s11) * PROD1_BITS'(s1_fx_reg);
        top_next    = TOP_BITS'(top_sum);
        bottom_next = TOP_BITS'(bottom_sum);
    end

    // ------------------------------------------------------------------
    // Stage 2: vertical blend
    // ------------------------------------------------------------------
    logic                 s2_valid_reg;
    logic                 s2_oor_reg;
    logic [F-1:0]         s2_fz_reg;
    logic [TOP_BITS-1:0]  s2_top_reg;
    logic [TOP_BITS-1:0]  s2_bottom_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_oor_reg    <= s1_oor_reg;
            s2_fz_reg     <= s1_fz_reg;
            s2_top_reg    <= top_next;
            s2_bottom_reg <= bottom_next;
        end
    end

    logic [WGT_BITS-1:0]    wz0;
    logic [PROD2_BITS-1:0]  blend_sum;
    logic [BLEND_BITS-1:0]  blend_next;

    always_comb begin
        wz0        = ONE - WGT_BITS'(s2_fz_reg);
        blend_sum  = PROD2_BITS'(s2_top_reg) * PROD2_BITS'(wz0)
                   + PROD2_BITS'(s2_bottom_reg) * PROD2_BITS'(s2_fz_reg);
        blend_next = BLEND_BITS'(blend_sum);
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by six through the reciprocal
    // ------------------------------------------------------------------
    logic                   s3_valid_reg;
    logic                   s3_oor_reg;
    logic [BLEND_BITS-1:0]  s3_blend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_oor_reg   <= s2_oor_reg;
            s3_blend_reg <= blend_next;
        end
    end

    logic [Q_BITS-1:0]      quot_in;
    logic [DIVP_BITS-1:0]   div_prod;
    logic [HEIGHT_BITS-1:0] height_next;

    always_comb begin
        quot_in  = s3_blend_reg[Q_SHIFT +: Q_BITS];
        div_prod = DIVP_BITS'(quot_in) * DIVP_BITS'(DIV6_MUL);
        // Drop the height of an out-of-range query
        height_next = s3_oor_reg ? '0 : div_prod[DIV6_SHIFT +: HEIGHT_BITS];
    end

    // ------------------------------------------------------------------
    // Output register: hold the result until the consumer takes it
    // ------------------------------------------------------------------
    logic [HEIGHT_BITS-1:0] out_height_reg;
    logic                   out_oor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_height_reg <= height_next;
            out_oor_reg    <= s3_oor_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_height       = out_height_reg;
    assign m_out_of_range = out_oor_reg;

endmodule

`default_nettype wire

### verif/tb_heightmap_bilinear_sampler_top.sv
// Self-checking testbench for the heightmap bilinear sampler top level.
`timescale 1ns / 1ps

module tb_heightmap_bilinear_sampler_top;

    import hmbs_pkg::*;

    // Give the pipeline a margin after the last result before touching the size
    // registers or ending the run.
    localparam int DRAIN_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 250;
    localparam int RANDOM_PHASES = 8;
    localparam int FRAC_MASK     = (1 << FRACTION_BITS) - 1;

    typedef struct {
        logic [HEIGHT_BITS-1:0] height;
        logic                   out_of_range;
    } height_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_write;
    reg_idx_t                   cfg_index;
    logic [CFG_BITS-1:0]        cfg_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_BITS-1:0]        s_command;
    logic [FIELD_BITS-1:0]      s_sample_column;
    logic [FIELD_BITS-1:0]      s_sample_row;
    logic [SAMPLE_BITS-1:0]     s_sample_value;
    logic signed [POS_BITS-1:0] s_pos_x;
    logic signed [POS_BITS-1:0] s_pos_z;
    logic                       m_valid;
    logic                       m_ready;
    logic [HEIGHT_BITS-1:0]     m_height;
    logic                       m_out_of_range;

    // Shadow of the block: raw size registers, sample store and the set of
    // entries that hold a written value (reading any other entry is illegal).
    logic [CFG_BITS-1:0]    width_reg;
    logic [CFG_BITS-1:0]    height_reg;
    logic [SAMPLE_BITS-1:0] sample_store [MAX_WIDTH*MAX_HEIGHT];
    bit                     sample_known [MAX_WIDTH*MAX_HEIGHT];

    height_result_t pending_heights[$];

    int  error_count;
    int  heights_checked;
    int  requests_accepted;
    int  size_settings;
    int  cycle_count;
    int  stall_left;
    bit  gaps_on;

    heightmap_bilinear_sampler_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_sample_column(s_sample_column),
        .s_sample_row   (s_sample_row),
        .s_sample_value (s_sample_value),
        .s_pos_x        (s_pos_x),
        .s_pos_z        (s_pos_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_height       (m_height),
        .m_out_of_range (m_out_of_range)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d heights still pending",
                     $time, cycle_count, pending_heights.size());
            $display("tb_heightmap_bilinear_sampler_top: done, errors");
            $finish;
        end
    end

    // Result side back-pressure: drop ready in random bursts while gaps are
    // enabled, hold it high otherwise.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest pending height.
    always @(posedge aclk) begin : check_results
        height_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_heights.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual height %0d oor %0b",
                         $time, m_height, m_out_of_range);
                error_count++;
            end else begin
                want = pending_heights.pop_front();
                heights_checked++;
                if (m_height !== want.height) begin
                    $display("%0t: height mismatch: expected %0d, actual %0d",
                             $time, want.height, m_height);
                    error_count++;
                end
                if (m_out_of_range !== want.out_of_range) begin
                    $display("%0t: out_of_range mismatch: expected %0b, actual %0b",
                             $time, want.out_of_range, m_out_of_range);
                    error_count++;
                end
            end
        end
    end

    // Size registers saturate to 1..max when used.
    function automatic int clamp_size(int raw, int max_size);
        if (raw < 1)
            return 1;
        if (raw > max_size)
            return max_size;
        return raw;
    endfunction

    function automatic bit inside_map(int x, int z);
        int last_x;
        int last_z;
        last_x = (clamp_size(width_reg, MAX_WIDTH) - 1) << FRACTION_BITS;
        last_z = (clamp_size(height_reg, MAX_HEIGHT) - 1) << FRACTION_BITS;
        return x >= 0 && z >= 0 && x <= last_x && z <= last_z;
    endfunction

    function automatic longint unsigned stored_sample(int col, int row);
        if (col >= MAX_WIDTH || row >= MAX_HEIGHT)
            return 0;
        return sample_store[row * MAX_WIDTH + col];
    endfunction

    // Bilinear blend of the four neighbors, scaled to Q8.8 and divided by six.
    function automatic height_result_t blend_height(int x, int z);
        height_result_t r;
        int x0, z0, x1, z1;
        longint unsigned fx, fz, one, top, bottom, blend;
        r.height       = '0;
        r.out_of_range = 1'b1;
        if (!inside_map(x, z))
            return r;
        one = longint'(1) << FRACTION_BITS;
        x0  = x >> FRACTION_BITS;
        z0  = z >> FRACTION_BITS;
        fx  = x & FRAC_MASK;
        fz  = z & FRAC_MASK;
        x1  = (fx != 0) ? x0 + 1 : x0;
        z1  = (fz != 0) ? z0 + 1 : z0;
        top    = stored_sample(x0, z0) * (one - fx) + stored_sample(x1, z0) * fx;
        bottom = stored_sample(x0, z1) * (one - fx) + stored_sample(x1, z1) * fx;
        blend  = top * (one - fz) + bottom * fz;
        r.height       = HEIGHT_BITS'((blend << 8) / (longint'(6) << (2 * FRACTION_BITS)));
        r.out_of_range = 1'b0;
        return r;
    endfunction

    function automatic int rand_pos();
        logic signed [POS_BITS-1:0] p;
        p = POS_BITS'($urandom);
        return int'(p);
    endfunction

    // In-range coordinate on one axis: the last line exactly, a point near the
    // hot spot (where samples are likely written already), or anywhere.
    function automatic int in_range_coord(int size, int hot);
        int last;
        int grid_idx;
        int sel;
        last = (size - 1) << FRACTION_BITS;
        sel  = $urandom_range(0, 9);
        if (sel == 0)
            return last;
        if (sel < 5) begin
            grid_idx = hot + $urandom_range(0, 7);
            if (grid_idx >= size - 1)
                return last;
            return (grid_idx << FRACTION_BITS) | $urandom_range(0, FRAC_MASK);
        end
        return $urandom_range(0, last);
    endfunction

    // Present one request, hold it until accepted, then update the shadow.
    task automatic send_request(input cmd_t cmd, input int col, input int row,
                                input int value, input int x, input int z);
        @(negedge aclk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_sample_column <= FIELD_BITS'(col);
        s_sample_row    <= FIELD_BITS'(row);
        s_sample_value  <= SAMPLE_BITS'(value);
        s_pos_x         <= POS_BITS'(x);
        s_pos_z         <= POS_BITS'(z);
        do @(posedge aclk); while (!s_ready);
        requests_accepted++;
        if (cmd == CMD_WRITE) begin
            sample_store[(row & 8'hFF) * MAX_WIDTH + (col & 8'hFF)] = SAMPLE_BITS'(value);
            sample_known[(row & 8'hFF) * MAX_WIDTH + (col & 8'hFF)] = 1'b1;
        end else begin
            pending_heights.push_back(blend_height(x, z));
        end
    endtask

    task automatic write_sample(input int col, input int row, input int value);
        send_request(CMD_WRITE, col, row, value, rand_pos(), rand_pos());
    endtask

    // Query a position. For an in-range one, first write any neighbor the
    // block may touch that still holds nothing; include the wrapped next
    // column and row so no in-range query's bank read lands on an unwritten entry.
    task automatic query_height(input int x, input int z);
        int c0;
        int r0;
        int col;
        int row;
        if (inside_map(x, z)) begin
            c0 = x >> FRACTION_BITS;
            r0 = z >> FRACTION_BITS;
            for (int dr = 0; dr < 2; dr++) begin
                for (int dc = 0; dc < 2; dc++) begin
                    col = (c0 + dc) % MAX_WIDTH;
                    row = (r0 + dr) % MAX_HEIGHT;
                    if (!sample_known[row * MAX_WIDTH + col])
                        write_sample(col, row, $urandom_range(0, 255));
                end
            end
        end
        send_request(CMD_QUERY, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), x, z);
    endtask

    // Release the request channel and wait until every height is back and the
    // pipeline has emptied behind the last write.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input reg_idx_t idx, input int value);
        @(negedge aclk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_BITS'(value);
        @(negedge aclk);
        cfg_write <= 1'b0;
        if (idx == REG_MAP_WIDTH)
            width_reg = CFG_BITS'(value);
        else
            height_reg = CFG_BITS'(value);
    endtask

    task automatic set_map_size(input int w, input int h);
        wait_drained();
        write_register(REG_MAP_WIDTH, w);
        write_register(REG_MAP_HEIGHT, h);
        size_settings++;
    endtask

    // Blends inside the first cell: exact corners, half steps, the largest
    // fractions, and a point exactly on a written sample.
    task automatic test_corner_blend();
        write_sample(0, 0, 0);
        write_sample(1, 0, 255);
        write_sample(0, 1, 128);
        write_sample(1, 1, 64);
        query_height(0, 0);
        query_height(128, 0);
        query_height(0, 128);
        query_height(255, 255);
        query_height(256, 256);
    endtask

    // Last column and row of the full map, and every way to fall off it.
    task automatic test_map_edges();
        write_sample(254, 254, 255);
        write_sample(255, 254, 255);
        write_sample(254, 255, 255);
        write_sample(255, 255, 255);
        query_height(255 << FRACTION_BITS, 255 << FRACTION_BITS);
        query_height((254 << FRACTION_BITS) + 255, (254 << FRACTION_BITS) + 255);
        query_height((255 << FRACTION_BITS) + 1, 0);
        query_height(0, (255 << FRACTION_BITS) + 1);
        query_height(-1, 0);
        query_height(0, -1);
        query_height(-65536, -65536);
        query_height(65535, 65535);
    endtask

    // Smallest map, zero and oversized register values that saturate.
    task automatic test_register_limits();
        set_map_size(1, 1);
        query_height(0, 0);
        query_height(1, 0);
        query_height(0, 1);
        set_map_size(0, 511);
        query_height(0, 255 << FRACTION_BITS);
        query_height(1, 0);
        query_height(0, (255 << FRACTION_BITS) + 1);
        set_map_size(257, 2);
        query_height(255 << FRACTION_BITS, 1 << FRACTION_BITS);
        query_height(0, (1 << FRACTION_BITS) + 1);
    endtask

    task automatic random_request(input int w, input int h, input int hot_col,
                                  input int hot_row);
        int pick;
        int last_x;
        int last_z;
        pick   = $urandom_range(0, 99);
        last_x = (w - 1) << FRACTION_BITS;
        last_z = (h - 1) << FRACTION_BITS;
        if (pick < 30) begin
            write_sample($urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
        end else if (pick < 40) begin
            write_sample((hot_col + $urandom_range(0, 7)) % MAX_WIDTH,
                         (hot_row + $urandom_range(0, 7)) % MAX_HEIGHT,
                         $urandom_range(0, 255));
        end else if (pick < 85) begin
            query_height(in_range_coord(w, hot_col), in_range_coord(h, hot_row));
        end else begin
            case ($urandom_range(0, 4))
                0: query_height(-int'($urandom_range(1, 65536)), in_range_coord(h, hot_row));
                1: query_height(in_range_coord(w, hot_col), -int'($urandom_range(1, 65536)));
                2: query_height(last_x + $urandom_range(1, 65535 - last_x),
                                in_range_coord(h, hot_row));
                3: query_height(in_range_coord(w, hot_col),
                                last_z + $urandom_range(1, 65535 - last_z));
                default: query_height(rand_pos(), rand_pos());
            endcase
        end
    endtask

    // Phases of random traffic under different map sizes; the last phase runs
    // back to back on both sides.
    task automatic test_random_traffic();
        int size_w [RANDOM_PHASES] = '{256, 1, 2, 511, -1, -2, 3, 256};
        int size_h [RANDOM_PHASES] = '{256, 1, 3, 0, -1, -2, 256, 256};
        int w;
        int h;
        int weff;
        int heff;
        int hot_col;
        int hot_row;
        int target;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // -1 picks a legal size, -2 any register value
            w = (size_w[ph] == -1) ? $urandom_range(1, 256) :
                (size_w[ph] == -2) ? $urandom_range(0, 511) : size_w[ph];
            h = (size_h[ph] == -1) ? $urandom_range(1, 256) :
                (size_h[ph] == -2) ? $urandom_range(0, 511) : size_h[ph];
            set_map_size(w, h);
            weff    = clamp_size(width_reg, MAX_WIDTH);
            heff    = clamp_size(height_reg, MAX_HEIGHT);
            hot_col = $urandom_range(0, weff - 1);
            hot_row = $urandom_range(0, heff - 1);
            gaps_on = (ph != RANDOM_PHASES - 1);
            target  = requests_accepted + PHASE_ITEMS;
            while (requests_accepted < target) begin
                // alternate stretches with and without gaps
                if (ph != RANDOM_PHASES - 1 && requests_accepted % 64 == 0)
                    gaps_on = ($urandom_range(0, 2) != 0);
                random_request(weff, heff, hot_col, hot_row);
            end
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_MAP_WIDTH;
        cfg_data        = '0;
        s_valid         = 1'b0;
        s_command       = CMD_WRITE;
        s_sample_column = '0;
        s_sample_row    = '0;
        s_sample_value  = '0;
        s_pos_x         = '0;
        s_pos_z         = '0;
        m_ready         = 1'b0;
        gaps_on         = 1'b1;
        width_reg       = CFG_BITS'(MAX_WIDTH);
        height_reg      = CFG_BITS'(MAX_HEIGHT);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_corner_blend();
        test_map_edges();
        test_register_limits();
        test_random_traffic();
        wait_drained();

        $display("Covered sample writes, in-range and off-map queries over %0d map sizes,",
                 size_settings);
        $display("%0d requests accepted, %0d heights checked, %0d errors.",
                 requests_accepted, heights_checked, error_count);
        if (error_count == 0) begin
            $display("tb_heightmap_bilinear_sampler_top: done, clean");
        end else begin
            $display("tb_heightmap_bilinear_sampler_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
hdl/hmbs_pkg.sv
hdl/hmbs_store.sv
hdl/heightmap_bilinear_sampler_top.sv
verif/tb_heightmap_bilinear_sampler_top.sv
